FILE: hdl/sktbl_pkg.sv
// Package for the sorted key/value table: operation codes, sequencer states
// and the per-cell control word. No dependencies.
package sktbl_pkg;

  localparam int DefTableDepth = 64;
  localparam int DefKeyWidth   = 32;
  localparam int DefValueWidth = 32;

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_APPLY
  } state_t;

  // One-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic insert;
    logic update;
    logic remove;
  } cell_ctrl_t;

endpackage

FILE: hdl/sorted_key_value_table_unit.sv
// Sorted key/value table: a row of TABLE_DEPTH cells kept in key order.
// Top level: sequencer, scan priority, result register. Depends on
// sktbl_pkg and sktbl_cell.
//
// Every request (add/update, search, remove) runs as follows: at the accept
// edge every cell compares its key with the request key in parallel; in the
// next cycle the first stopping cell is picked by a prefix OR over the row,
// and all cells shift, insert or update at once while the result is
// registered, unless an earlier result still waits on out_stall, which holds
// this apply step. The next request is taken once the apply step is done,
// while its result may still wait on out_stall. The order mode is sampled at
// the compare, so write it only while the table is idle. No clearing pass
// after reset: slots past entry_count are never read.
module sorted_key_value_table_unit #(
  parameter int TABLE_DEPTH = sktbl_pkg::DefTableDepth,
  parameter int KEY_WIDTH   = sktbl_pkg::DefKeyWidth,
  parameter int VALUE_WIDTH = sktbl_pkg::DefValueWidth,
  parameter int CntWidth    = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_kind,
  input  logic [KEY_WIDTH-1:0]   in_key,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] out_value_out,
  output logic                   out_found,
  output logic                   out_rejected_full,
  output logic [CntWidth-1:0]    out_entry_count
);
  import sktbl_pkg::*;

  localparam int PrefixSteps = $clog2(TABLE_DEPTH);

  state_t state_r, state_nxt;

  logic                   descending_r;
  logic [CntWidth-1:0]    count_r, count_nxt;
  logic [1:0]             kind_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0] out_value_r;
  logic                   out_found_r, out_rejected_r;
  logic [CntWidth-1:0]    out_count_r;

  logic accept, apply_fire, apply_en;
  logic hit, full, found, rejected;
  cell_ctrl_t ctrl;

  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [TABLE_DEPTH-1:0] stop_vec;
  logic [TABLE_DEPTH-1:0] before_vec;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [KEY_WIDTH-1:0]   cell_key   [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] cell_value [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] cell_vsel  [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] hit_value;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (accept) state_nxt = ST_APPLY;
      ST_APPLY: if (apply_fire) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    apply_en = 1'b0;
    case (state_r)
      ST_IDLE:  in_stall = 1'b0;
      ST_APPLY: apply_en = 1'b1;
      default:  in_stall = 1'b1;
    endcase
  end

  assign accept     = in_valid && !in_stall;
  assign apply_fire = apply_en && !(out_valid_r && out_stall);

  // Exclusive prefix OR: before_vec[i] is set when an earlier cell stopped.
  always_comb begin
    before_vec = stop_vec << 1;
    for (int s = 0; s < PrefixSteps; s++) begin
      before_vec = before_vec | (before_vec << (1 << s));
    end
  end

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_value = hit_value | cell_vsel[i];
    end
  end

  assign hit      = |hit_vec;
  assign full     = (count_r == CntWidth'(TABLE_DEPTH));
  assign found    = hit && (kind_r == KIND_ADD || kind_r == KIND_SEARCH
                            || kind_r == KIND_REMOVE);
  assign rejected = (kind_r == KIND_ADD) && !hit && full;

  always_comb begin
    ctrl        = '0;
    ctrl.insert = apply_fire && (kind_r == KIND_ADD) && !hit && !full;
    ctrl.update = apply_fire && (kind_r == KIND_ADD) && hit;
    ctrl.remove = apply_fire && (kind_r == KIND_REMOVE) && hit;
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.insert) begin
      count_nxt = count_r + CntWidth'(1);
    end else if (ctrl.remove) begin
      count_nxt = count_r - CntWidth'(1);
    end
  end

  assign out_valid_nxt = apply_fire ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      descending_r <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        descending_r <= cfg_wr_data;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (apply_fire) begin
      out_value_r    <= found ? hit_value : '0;
      out_found_r    <= found;
      out_rejected_r <= rejected;
      out_count_r    <= count_nxt;
    end
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]   lower_key, upper_key;
    logic [VALUE_WIDTH-1:0] lower_value, upper_value;

    assign slot_valid[i] = (CntWidth'(i) < count_r);

    if (i == 0) begin : g_first
      assign lower_key   = cell_key[i];
      assign lower_value = cell_value[i];
    end else begin : g_mid_lo
      assign lower_key   = cell_key[i-1];
      assign lower_value = cell_value[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign upper_key   = cell_key[i];
      assign upper_value = cell_value[i];
    end else begin : g_mid_hi
      assign upper_key   = cell_key[i+1];
      assign upper_value = cell_value[i+1];
    end

    sktbl_cell #(
      .KEY_WIDTH  (KEY_WIDTH),
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .cmp_en      (accept),
      .probe_key   (in_key),
      .descending  (descending_r),
      .is_remove   (in_kind == KIND_REMOVE),
      .slot_valid  (slot_valid[i]),
      .ctrl        (ctrl),
      .new_key     (key_r),
      .new_value   (value_r),
      .earlier_stop(before_vec[i]),
      .lower_key   (lower_key),
      .lower_value (lower_value),
      .upper_key   (upper_key),
      .upper_value (upper_value),
      .key_q       (cell_key[i]),
      .value_q     (cell_value[i]),
      .stop_q      (stop_vec[i]),
      .hit_sel     (hit_vec[i]),
      .value_sel   (cell_vsel[i])
    );
  end

  assign out_valid         = out_valid_r;
  assign out_value_out     = out_value_r;
  assign out_found         = out_found_r;
  assign out_rejected_full = out_rejected_r;
  assign out_entry_count   = out_count_r;

endmodule

FILE: hdl/sktbl_cell.sv
// One slot of the table row: holds a key/value pair, compares it with the
// probe key and shifts to or from its neighbors. Depends on sktbl_pkg.
module sktbl_cell #(
  parameter int KEY_WIDTH   = sktbl_pkg::DefKeyWidth,
  parameter int VALUE_WIDTH = sktbl_pkg::DefValueWidth
) (
  input  logic                   clk,
  input  logic                   cmp_en,
  input  logic [KEY_WIDTH-1:0]   probe_key,
  input  logic                   descending,
  input  logic                   is_remove,
  input  logic                   slot_valid,
  input  sktbl_pkg::cell_ctrl_t  ctrl,
  input  logic [KEY_WIDTH-1:0]   new_key,
  input  logic [VALUE_WIDTH-1:0] new_value,
  input  logic                   earlier_stop,
  input  logic [KEY_WIDTH-1:0]   lower_key,
  input  logic [VALUE_WIDTH-1:0] lower_value,
  input  logic [KEY_WIDTH-1:0]   upper_key,
  input  logic [VALUE_WIDTH-1:0] upper_value,
  output logic [KEY_WIDTH-1:0]   key_q,
  output logic [VALUE_WIDTH-1:0] value_q,
  output logic                   stop_q,
  output logic                   hit_sel,
  output logic [VALUE_WIDTH-1:0] value_sel
);
  import sktbl_pkg::*;

  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic                   stop_r, stop_nxt;
  logic                   hit_r, hit_nxt;
  logic                   eq;
  logic                   in_order;
  logic                   sel;

  assign eq       = (key_r == probe_key);
  assign in_order = descending ? ($signed(key_r) >= $signed(probe_key))
                               : ($signed(key_r) <= $signed(probe_key));

  // Scan stop: remove looks for an equal key only; add and search stop at
  // the first slot that breaks the order, matches, or lies past the end.
  always_comb begin
    stop_nxt = stop_r;
    hit_nxt  = hit_r;
    if (cmp_en) begin
      hit_nxt = slot_valid & eq;
      if (is_remove) begin
        stop_nxt = slot_valid & eq;
      end else begin
        stop_nxt = !slot_valid | eq | !in_order;
      end
    end
  end

  assign sel = stop_r & !earlier_stop;

  always_comb begin
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctrl.insert) begin
      if (sel) begin
        key_nxt   = new_key;
        value_nxt = new_value;
      end else if (earlier_stop) begin
        key_nxt   = lower_key;
        value_nxt = lower_value;
      end
    end
    if (ctrl.remove && (sel || earlier_stop)) begin
      key_nxt   = upper_key;
      value_nxt = upper_value;
    end
    if (ctrl.update && sel) begin
      value_nxt = new_value;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    stop_r  <= stop_nxt;
    hit_r   <= hit_nxt;
  end

  assign key_q     = key_r;
  assign value_q   = value_r;
  assign stop_q    = stop_r;
  assign hit_sel   = sel & hit_r;
  assign value_sel = hit_sel ? value_r : '0;

endmodule

FILE: dv/testbench.sv
// Testbench for sorted_key_value_table_unit: directed table, then random phases
// checked against an in-bench model of the sorted table. Depends on sktbl_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sktbl_pkg::*;

  localparam int TableDepth = DefTableDepth;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] value_out;
    logic        found;
    logic        rejected_full;
    logic [6:0]  entry_count;
  } result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
    logic        typed;
    result_t     want;
  } stim_row_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = KIND_SEARCH;
  logic [31:0] in_key = '0;
  logic [31:0] in_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_value_out;
  logic        out_found;
  logic        out_rejected_full;
  logic [6:0]  out_entry_count;

  // Model of the table contents and mode
  logic signed [31:0] tbl_key   [TableDepth];
  logic        [31:0] tbl_value [TableDepth];
  int                 n_stored = 0;
  bit                 order_desc = 1'b0;

  result_t     pending_results [$];
  int          fail_count = 0;
  int unsigned word_count = 0;
  int unsigned stall_style = 0;
  int unsigned stall_hold = 0;
  logic [31:0] key_pool [16];

  sorted_key_value_table_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_key            (in_key),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value_out     (out_value_out),
    .out_found         (out_found),
    .out_rejected_full (out_rejected_full),
    .out_entry_count   (out_entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic bit key_in_order(input logic signed [31:0] stored,
                                      input logic signed [31:0] probe);
    return order_desc ? (stored >= probe) : (stored <= probe);
  endfunction

  function automatic result_t table_apply(input logic [1:0] kind,
                                          input logic signed [31:0] key,
                                          input logic [31:0] value);
    result_t r;
    int      slot;
    bit      hit;
    r = '0;
    slot = 0;
    hit = 1'b0;
    if (kind == KIND_ADD || kind == KIND_SEARCH) begin
      // Scan while the order relation holds; stop on an equal key
      while (!hit && slot < n_stored && key_in_order(tbl_key[slot], key)) begin
        if (tbl_key[slot] == key) hit = 1'b1;
        else slot++;
      end
      if (hit) begin
        r.found = 1'b1;
        r.value_out = tbl_value[slot];
        if (kind == KIND_ADD) tbl_value[slot] = value;
      end else if (kind == KIND_ADD) begin
        if (n_stored >= TableDepth) begin
          r.rejected_full = 1'b1;
        end else begin
          for (int j = n_stored; j > slot; j--) begin
            tbl_key[j] = tbl_key[j-1];
            tbl_value[j] = tbl_value[j-1];
          end
          tbl_key[slot] = key;
          tbl_value[slot] = value;
          n_stored++;
        end
      end
    end else if (kind == KIND_REMOVE) begin
      while (slot < n_stored && tbl_key[slot] != key) slot++;
      if (slot < n_stored) begin
        r.found = 1'b1;
        r.value_out = tbl_value[slot];
        for (int j = slot; j + 1 < n_stored; j++) begin
          tbl_key[j] = tbl_key[j+1];
          tbl_value[j] = tbl_value[j+1];
        end
        n_stored--;
      end
    end
    r.entry_count = 7'(n_stored);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if ((word_count / 48) % 4 == 1) return 0;
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [31:0] stored_key();
    if (n_stored == 0) return $urandom;
    return tbl_key[$urandom_range(0, n_stored - 1)];
  endfunction

  task automatic send_word(input logic [1:0] kind, input logic [31:0] key,
                           input logic [31:0] value, input bit typed,
                           input result_t typed_want);
    int unsigned gap;
    result_t     predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_key <= key;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    predicted = table_apply(kind, key, value);
    pending_results.push_back(typed ? typed_want : predicted);
    word_count++;
  endtask

  // Drop valid, let the table drain, then write the order mode
  task automatic set_order(input bit descending);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= descending;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    order_desc = descending;
  endtask

  always @(posedge clk) begin : recv_pace
    int unsigned roll;
    roll = $urandom_range(0, 999);
    if (roll < 4) stall_style <= $urandom_range(0, 3);
    if (stall_hold != 0) begin
      out_stall <= 1'b1;
      stall_hold <= stall_hold - 1;
    end else begin
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= (roll % 8 == 0);
        2: out_stall <= (roll % 2 == 0);
        default: begin
          if (roll % 50 == 0) begin
            out_stall <= 1'b1;
            stall_hold <= $urandom_range(10, 30);
          end else begin
            out_stall <= 1'b0;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word value_out=%h found=%b rejected_full=%b count=%0d",
                 $time, out_value_out, out_found, out_rejected_full, out_entry_count);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_value_out !== want.value_out) begin
          $display("%0t: value_out expected %h got %h", $time, want.value_out,
                   out_value_out);
          fail_count++;
        end
        if (out_found !== want.found) begin
          $display("%0t: found expected %b got %b", $time, want.found, out_found);
          fail_count++;
        end
        if (out_rejected_full !== want.rejected_full) begin
          $display("%0t: rejected_full expected %b got %b", $time, want.rejected_full,
                   out_rejected_full);
          fail_count++;
        end
        if (out_entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
                   out_entry_count);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t   directed_rows [17];
    int          p;
    int          i;
    int          guard;
    int unsigned roll;
    logic [1:0]  kind;
    logic [31:0] k;

    // Ascending mode; empty table, extremes, update, miss, double remove
    directed_rows = '{
      '{KIND_SEARCH, 32'd5,        32'd0,        1'b1, '{32'd0,        1'b0, 1'b0, 7'd0}},
      '{KIND_REMOVE, 32'd5,        32'd0,        1'b1, '{32'd0,        1'b0, 1'b0, 7'd0}},
      '{KIND_UNUSED, 32'hffffffff, 32'hffffffff, 1'b1, '{32'd0,        1'b0, 1'b0, 7'd0}},
      '{KIND_ADD,    32'h80000000, 32'h7fffffff, 1'b1, '{32'd0,        1'b0, 1'b0, 7'd1}},
      '{KIND_ADD,    32'h7fffffff, 32'h80000000, 1'b1, '{32'd0,        1'b0, 1'b0, 7'd2}},
      '{KIND_ADD,    32'h00000000, 32'h00000000, 1'b1, '{32'd0,        1'b0, 1'b0, 7'd3}},
      '{KIND_ADD,    32'hffffffff, 32'hffffffff, 1'b1, '{32'd0,        1'b0, 1'b0, 7'd4}},
      '{KIND_ADD,    32'h7fffffff, 32'h00000001, 1'b1, '{32'h80000000, 1'b1, 1'b0, 7'd4}},
      '{KIND_SEARCH, 32'h80000000, 32'h00000000, 1'b1, '{32'h7fffffff, 1'b1, 1'b0, 7'd4}},
      '{KIND_SEARCH, 32'd12345,    32'h00000000, 1'b1, '{32'd0,        1'b0, 1'b0, 7'd4}},
      '{KIND_REMOVE, 32'h00000000, 32'h00000000, 1'b1, '{32'd0,        1'b1, 1'b0, 7'd3}},
      '{KIND_REMOVE, 32'h00000000, 32'h00000000, 1'b1, '{32'd0,        1'b0, 1'b0, 7'd3}},
      '{KIND_UNUSED, 32'h00000000, 32'h00000000, 1'b1, '{32'd0,        1'b0, 1'b0, 7'd3}},
      '{KIND_ADD,    32'h55aa55aa, 32'ha55aa55a, 1'b0, '{32'd0,        1'b0, 1'b0, 7'd0}},
      '{KIND_SEARCH, 32'hffffffff, 32'h00000000, 1'b1, '{32'hffffffff, 1'b1, 1'b0, 7'd4}},
      '{KIND_REMOVE, 32'h80000000, 32'h00000000, 1'b1, '{32'h7fffffff, 1'b1, 1'b0, 7'd3}},
      '{KIND_ADD,    32'h80000001, 32'h00000002, 1'b0, '{32'd0,        1'b0, 1'b0, 7'd0}}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_order(1'b0);

    foreach (directed_rows[row]) begin
      send_word(directed_rows[row].kind, directed_rows[row].key, directed_rows[row].value,
                directed_rows[row].typed, directed_rows[row].want);
    end

    // Mode flips every two phases without clearing the table
    for (p = 0; p < 12; p++) begin
      set_order(((p / 2) % 2) == 1);
      key_pool[0] = 32'h80000000;
      key_pool[1] = 32'h7fffffff;
      key_pool[2] = 32'h00000000;
      key_pool[3] = 32'hffffffff;
      for (i = 4; i < 16; i++) key_pool[i] = $urandom;
      case (p % 3)
        0: begin
          for (i = 0; i < 150; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) kind = KIND_ADD;
            else if (roll < 70) kind = KIND_SEARCH;
            else if (roll < 95) kind = KIND_REMOVE;
            else kind = KIND_UNUSED;
            k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 15)] : $urandom;
            send_word(kind, k, $urandom, 1'b0, '0);
          end
        end
        1: begin
          guard = 0;
          while (n_stored < TableDepth && guard < 200) begin
            send_word(KIND_ADD, $urandom, $urandom, 1'b0, '0);
            guard++;
          end
          // Full table: new keys bounce, updates still land
          for (i = 0; i < 30; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 50) send_word(KIND_ADD, $urandom, $urandom, 1'b0, '0);
            else if (roll < 80) send_word(KIND_ADD, stored_key(), $urandom, 1'b0, '0);
            else if (roll < 90) send_word(KIND_SEARCH, stored_key(), $urandom, 1'b0, '0);
            else send_word(KIND_UNUSED, $urandom, $urandom, 1'b0, '0);
          end
        end
        default: begin
          for (i = 0; i < 100; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 55) send_word(KIND_REMOVE, stored_key(), $urandom, 1'b0, '0);
            else if (roll < 70) send_word(KIND_REMOVE, $urandom, $urandom, 1'b0, '0);
            else if (roll < 85) send_word(KIND_SEARCH, stored_key(), $urandom, 1'b0, '0);
            else if (roll < 95)
              send_word(KIND_ADD, key_pool[$urandom_range(0, 15)], $urandom, 1'b0, '0);
            else send_word(KIND_UNUSED, $urandom, $urandom, 1'b0, '0);
          end
        end
      endcase
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
hdl/sktbl_pkg.sv
hdl/sktbl_cell.sv
hdl/sorted_key_value_table_unit.sv
dv/testbench.sv
